@@ rtl/spc_pkg.sv @@
// ----------------------------------------------------------------------------
// spc_pkg
// Shared constants, types and helpers of the sensor packet checker.
// ----------------------------------------------------------------------------
`default_nettype none

package spc_pkg;

  // Packet geometry
  localparam int unsigned PACKET_BYTES = 60;
  localparam int unsigned CNT_W        = $clog2(PACKET_BYTES + 1);
  localparam int unsigned SUM_LIMIT    = 56;

  // Field offsets inside a packet
  localparam int unsigned OFS_MAGIC   = 0;
  localparam int unsigned OFS_VERSION = 2;
  localparam int unsigned OFS_PTYPE   = 3;
  localparam int unsigned OFS_SIZE    = 4;
  localparam int unsigned OFS_NODE    = 8;
  localparam int unsigned OFS_CAP     = 20;
  localparam int unsigned OFS_PAYT    = 24;
  localparam int unsigned OFS_PAYB    = 28;
  localparam int unsigned OFS_SEQ     = 40;
  localparam int unsigned OFS_TS      = 44;
  localparam int unsigned OFS_BATT    = 48;
  localparam int unsigned OFS_SIG     = 51;
  localparam int unsigned OFS_ERR     = 53;
  localparam int unsigned OFS_CKSUM   = 56;

  // Configuration
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [15:0] MAGIC_RESET   = 16'hC32B;
  localparam logic [7:0]  VERSION_RESET = 8'd1;

  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_MAGIC   = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_VERSION = cfg_idx_t'(1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SIZE    = 2'd1,
    ST_MAGIC   = 2'd2,
    ST_VERSION = 2'd3
  } status_e;

  // Per-packet captured state handed to the checker
  typedef struct packed {
    cnt_t        pos;
    logic [15:0] sum;
    logic [15:0] magic;
    logic [7:0]  version;
    logic [15:0] size;
    logic [15:0] cksum;
    logic [7:0]  ptype;
    logic [31:0] node;
    logic [15:0] cap;
    logic [7:0]  payt;
    logic [31:0] payb;
    logic [31:0] seq;
    logic [31:0] ts;
    logic [15:0] batt;
    logic [7:0]  sig;
    logic [7:0]  err;
  } capture_t;

  typedef struct packed {
    status_e            status;
    logic [7:0]         pkt_kind;
    logic [31:0]        node_id;
    logic [15:0]        capability;
    logic [7:0]         value_kind;
    logic [31:0]        payload_bits;
    logic [31:0]        seq_number;
    logic [31:0]        sender_ms;
    logic [15:0]        battery_millivolts;
    logic signed [7:0]  signal_level;
    logic [7:0]         node_error;
    logic               checksum_ok;
  } result_t;

  // True when pos lies in [ofs, ofs+len)
  function automatic logic in_span(cnt_t pos, int unsigned ofs, int unsigned len);
    return (32'(pos) >= ofs) && (32'(pos) < ofs + len);
  endfunction

endpackage

`default_nettype wire

@@ rtl/spc_if.sv @@
// ----------------------------------------------------------------------------
// spc_byte_if / spc_result_if
// Valid/ready channels for packet bytes and check results.
// ----------------------------------------------------------------------------
`default_nettype none

interface spc_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface spc_result_if;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [7:0]        pkt_kind;
  logic [31:0]       node_id;
  logic [15:0]       capability;
  logic [7:0]        value_kind;
  logic [31:0]       payload_bits;
  logic [31:0]       seq_number;
  logic [31:0]       sender_ms;
  logic [15:0]       battery_millivolts;
  logic signed [7:0] signal_level;
  logic [7:0]        node_error;
  logic              checksum_ok;

  modport source (
    output valid, output status, output pkt_kind, output node_id,
    output capability, output value_kind, output payload_bits,
    output seq_number, output sender_ms, output battery_millivolts,
    output signal_level, output node_error, output checksum_ok,
    input  ready
  );
  modport sink (
    input  valid, input status, input pkt_kind, input node_id,
    input  capability, input value_kind, input payload_bits,
    input  seq_number, input sender_ms, input battery_millivolts,
    input  signal_level, input node_error, input checksum_ok,
    output ready
  );
endinterface

`default_nettype wire

@@ rtl/sensor_packet_checker.sv @@
// ----------------------------------------------------------------------------
// sensor_packet_checker
// Byte-serial sensor packet checker: counts, sums and captures fields, and
// gives one status/field result per packet on the byte flagged as last.
//
//   channel     dir  payload                               moves per request
//   byte_in     in   data_byte, last_byte                  one packet byte
//   result_out  out  status, extracted fields, checksum_ok one packet result
//   cfg_*       in   cfg_idx_i, cfg_wdata_i                one register write
//
// One byte is taken per cycle; the capture registers update at the accepting
// edge and the result of a last byte is in the result buffer the cycle after.
// byte_in.ready drops only while the two-entry result buffer is full.
// Reset clears the byte count, the sum and the buffer, and loads the
// expected magic and version defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_packet_checker (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  spc_byte_if.sink                       byte_in,
  spc_result_if.source                   result_out,
  input  wire logic                      cfg_we_i,
  input  wire spc_pkg::cfg_idx_t         cfg_idx_i,
  input  wire logic [spc_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import spc_pkg::*;

  logic [15:0] exp_magic_q;
  logic [7:0]  exp_version_q;
  logic        accept;
  logic        full;
  capture_t    cap;
  result_t     res;
  result_t     res_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_magic_q   <= MAGIC_RESET;
      exp_version_q <= VERSION_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAGIC:   exp_magic_q   <= cfg_wdata_i[15:0];
        CFG_VERSION: exp_version_q <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign byte_in.ready = !full;
  assign accept        = byte_in.valid && !full;

  spc_capture u_capture (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .data_byte_i (byte_in.data_byte),
    .last_byte_i (byte_in.last_byte),
    .cap_o       (cap)
  );

  spc_check u_check (
    .cap_i         (cap),
    .exp_magic_i   (exp_magic_q),
    .exp_version_i (exp_version_q),
    .res_o         (res)
  );

  spc_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept && byte_in.last_byte),
    .data_i  (res),
    .full_o  (full),
    .valid_o (result_out.valid),
    .pop_i   (result_out.ready),
    .data_o  (res_out)
  );

  assign result_out.status             = res_out.status;
  assign result_out.pkt_kind           = res_out.pkt_kind;
  assign result_out.node_id            = res_out.node_id;
  assign result_out.capability         = res_out.capability;
  assign result_out.value_kind         = res_out.value_kind;
  assign result_out.payload_bits       = res_out.payload_bits;
  assign result_out.seq_number         = res_out.seq_number;
  assign result_out.sender_ms          = res_out.sender_ms;
  assign result_out.battery_millivolts = res_out.battery_millivolts;
  assign result_out.signal_level       = res_out.signal_level;
  assign result_out.node_error         = res_out.node_error;
  assign result_out.checksum_ok        = res_out.checksum_ok;

endmodule

`default_nettype wire

@@ rtl/spc_capture.sv @@
// ----------------------------------------------------------------------------
// spc_capture
// Byte counter, running sum and little-endian field capture registers.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_capture (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [7:0]        data_byte_i,
  input  wire logic              last_byte_i,
  output spc_pkg::capture_t      cap_o
);
  import spc_pkg::*;

  cnt_t        pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  capture_t    fld_q, fld_d;

  always_comb begin
    pos_d = pos_q;
    sum_d = sum_q;
    fld_d = fld_q;
    if (accept_i) begin
      if (last_byte_i) begin
        pos_d = '0;
        sum_d = '0;
      end else if (pos_q < cnt_t'(PACKET_BYTES)) begin
        pos_d = pos_q + cnt_t'(1);
        if (pos_q < cnt_t'(SUM_LIMIT)) begin
          sum_d = sum_q + 16'(data_byte_i);
        end
      end
      // Multi-byte fields sit on aligned offsets, so low count bits pick the lane
      if (in_span(pos_q, OFS_MAGIC, 2))   fld_d.magic[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_VERSION, 1)) fld_d.version = data_byte_i;
      if (in_span(pos_q, OFS_PTYPE, 1))   fld_d.ptype = data_byte_i;
      if (in_span(pos_q, OFS_SIZE, 2))    fld_d.size[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_NODE, 4))    fld_d.node[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_CAP, 2))     fld_d.cap[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_PAYT, 1))    fld_d.payt = data_byte_i;
      if (in_span(pos_q, OFS_PAYB, 4))    fld_d.payb[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_SEQ, 4))     fld_d.seq[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_TS, 4))      fld_d.ts[{pos_q[1:0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_BATT, 2))    fld_d.batt[{pos_q[0], 3'b000} +: 8] = data_byte_i;
      if (in_span(pos_q, OFS_SIG, 1))     fld_d.sig = data_byte_i;
      if (in_span(pos_q, OFS_ERR, 1))     fld_d.err = data_byte_i;
      if (in_span(pos_q, OFS_CKSUM, 2))   fld_d.cksum[{pos_q[0], 3'b000} +: 8] = data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
    end
  end

  // Field captures need no reset: a passing packet rewrites all of them
  always_ff @(posedge clk_i) begin
    fld_q <= fld_d;
  end

  always_comb begin
    cap_o     = fld_q;
    cap_o.pos = pos_q;
    cap_o.sum = sum_q;
  end

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= cnt_t'(PACKET_BYTES))
    else $error("byte count past packet length");

  a_last_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_byte_i |=> pos_q == '0 && sum_q == '0)
    else $error("packet state not cleared after last byte");

  a_sum_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && !last_byte_i && pos_q >= cnt_t'(SUM_LIMIT) |=> $stable(sum_q))
    else $error("sum changed past checksum field");

endmodule

`default_nettype wire

@@ rtl/spc_check.sv @@
// ----------------------------------------------------------------------------
// spc_check
// Status evaluation and field extraction for a completed packet.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_check (
  input  wire spc_pkg::capture_t cap_i,
  input  wire logic [15:0]   exp_magic_i,
  input  wire logic [7:0]    exp_version_i,
  output spc_pkg::result_t   res_o
);
  import spc_pkg::*;

  status_e status;

  // Checks in priority order: length, magic, version, size field
  always_comb begin
    if (cap_i.pos != cnt_t'(PACKET_BYTES - 1)) begin
      status = ST_SIZE;
    end else if (cap_i.magic != exp_magic_i) begin
      status = ST_MAGIC;
    end else if (cap_i.version != exp_version_i) begin
      status = ST_VERSION;
    end else if (cap_i.size != 16'(PACKET_BYTES)) begin
      status = ST_SIZE;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    res_o        = '0;
    res_o.status = status;
    if (status == ST_OK) begin
      res_o.pkt_kind           = cap_i.ptype;
      res_o.node_id            = cap_i.node;
      res_o.capability         = cap_i.cap;
      res_o.value_kind         = cap_i.payt;
      res_o.payload_bits       = cap_i.payb;
      res_o.seq_number         = cap_i.seq;
      res_o.sender_ms          = cap_i.ts;
      res_o.battery_millivolts = cap_i.batt;
      res_o.signal_level       = cap_i.sig;
      res_o.node_error         = cap_i.err;
      res_o.checksum_ok        = (cap_i.cksum == cap_i.sum);
    end
  end

endmodule

`default_nettype wire

@@ rtl/spc_result_fifo.sv @@
// ----------------------------------------------------------------------------
// spc_result_fifo
// Two-entry result buffer between the checker and the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module spc_result_fifo (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push_i,
  input  wire spc_pkg::result_t data_i,
  output logic             full_o,
  output logic             valid_o,
  input  wire logic        pop_i,
  output spc_pkg::result_t data_o
);
  import spc_pkg::*;

  result_t    mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  assign full_o  = cnt_q[1];
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3)
    else $error("result buffer count out of range");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("result pushed into full buffer");

  a_ptr_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q))
    else $error("buffer pointers disagree with count");

endmodule

`default_nettype wire
